@@ rtl/core/klsf_pkg.sv @@
`timescale 1ns / 1ps
package klsf_pkg;

    localparam int KEY_CHARS_DEF = 31;
    localparam int LEN_W         = 5;
    localparam int FIFO_DEPTH    = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int KEY_HI_W      = 56;
    localparam int KEY_REG_CHARS = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN    = 3'd4;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // one queue entry: len buffered key bytes, then one tail item
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       tail;
        logic             status;
        logic             matched;
    } t_push;

endpackage

@@ rtl/core/klsf_front.sv @@
`timescale 1ns / 1ps
module klsf_front #(
    parameter int KEY_CHARS = klsf_pkg::KEY_CHARS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [klsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [klsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_fifo_full,
    input  logic                                i_snap_busy,
    output logic                                o_push_valid,
    output klsf_pkg::t_push                     o_push,
    output logic                                o_snap_load,
    output logic [KEY_CHARS*8-1:0]              o_key_flat
);
    import klsf_pkg::*;

    localparam int FW = $clog2(KEY_CHARS + 1);
    localparam int IW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;

    logic [63:0]         r_key_lo;
    logic [63:0]         r_key_mid_lo;
    logic [63:0]         r_key_mid_hi;
    logic [KEY_HI_W-1:0] r_key_hi;
    logic [4:0]          r_key_len;

    logic          r_in_key, n_in_key;
    logic          r_keep, n_keep;
    logic          r_dropped, n_dropped;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_key [KEY_CHARS];

    logic [KEY_REG_CHARS*8-1:0] cfg_chars;
    logic                       bytes_eq;
    logic                       key_match;
    logic                       accept;
    logic                       is_delim;
    logic                       key_wr;

    assign cfg_chars = {r_key_hi, r_key_mid_hi, r_key_mid_lo, r_key_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo     <= '0;
            r_key_mid_lo <= '0;
            r_key_mid_hi <= '0;
            r_key_hi     <= '0;
            r_key_len    <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_LO:     r_key_lo     <= i_cfg_data;
                CFG_KEY_MID_LO: r_key_mid_lo <= i_cfg_data;
                CFG_KEY_MID_HI: r_key_mid_hi <= i_cfg_data;
                CFG_KEY_HI:     r_key_hi     <= i_cfg_data[KEY_HI_W-1:0];
                CFG_KEY_LEN:    r_key_len    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        bytes_eq = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if ((FW'(i) < r_fill) && (r_key[i] != cfg_chars[8*i +: 8])) begin
                bytes_eq = 1'b0;
            end
        end
    end

    assign key_match = (r_key_len != 5'd0) && (LEN_W'(r_fill) == r_key_len) && bytes_eq;

    assign o_in_stall = i_fifo_full | (i_snap_busy & r_in_key);
    assign accept     = i_in_valid & ~o_in_stall;
    assign is_delim   = (i_data_byte == CHAR_COLON) || (i_data_byte == CHAR_NEWLINE)
                        || (r_fill >= FW'(KEY_CHARS));

    always_comb begin
        n_in_key     = r_in_key;
        n_keep       = r_keep;
        n_dropped    = r_dropped;
        n_fill       = r_fill;
        key_wr       = 1'b0;
        o_push_valid = 1'b0;
        o_snap_load  = 1'b0;
        o_push       = '{len: '0, tail: i_data_byte, status: 1'b0, matched: 1'b0};
        if (accept) begin
            if (i_opcode == OP_DATA) begin
                if (r_in_key) begin
                    if (is_delim) begin
                        if (key_match) begin
                            n_keep    = 1'b0;
                            n_dropped = 1'b1;
                        end else begin
                            n_keep       = 1'b1;
                            o_push_valid = 1'b1;
                            o_push.len   = LEN_W'(r_fill);
                            o_snap_load  = (r_fill != '0);
                        end
                        n_in_key = (i_data_byte == CHAR_NEWLINE);
                        n_fill   = '0;
                    end else begin
                        key_wr = 1'b1;
                        n_fill = r_fill + FW'(1);
                    end
                end else begin
                    o_push_valid = r_keep;
                    if (i_data_byte == CHAR_NEWLINE) begin
                        n_in_key = 1'b1;
                    end
                end
            end else begin
                o_push_valid   = 1'b1;
                o_push.len     = r_in_key ? LEN_W'(r_fill) : '0;
                o_push.tail    = 8'd0;
                o_push.status  = 1'b1;
                o_push.matched = r_dropped;
                o_snap_load    = r_in_key && (r_fill != '0);
                n_in_key       = 1'b1;
                n_keep         = 1'b1;
                n_dropped      = 1'b0;
                n_fill         = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_key  <= 1'b1;
            r_keep    <= 1'b1;
            r_dropped <= 1'b0;
            r_fill    <= '0;
        end else begin
            r_in_key  <= n_in_key;
            r_keep    <= n_keep;
            r_dropped <= n_dropped;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key[r_fill[IW-1:0]] <= i_data_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < KEY_CHARS; i++) begin
            o_key_flat[8*i +: 8] = r_key[i];
        end
    end

endmodule

@@ rtl/core/klsf_fifo.sv @@
`timescale 1ns / 1ps
module klsf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  klsf_pkg::t_push i_data,
    input  logic            i_pop,
    output klsf_pkg::t_push o_head,
    output logic            o_empty,
    output logic            o_full
);
    import klsf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_push         r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/klsf_back.sv @@
`timescale 1ns / 1ps
module klsf_back #(
    parameter int KEY_CHARS = klsf_pkg::KEY_CHARS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  klsf_pkg::t_push        i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic                   i_snap_load,
    input  logic [KEY_CHARS*8-1:0] i_key_flat,
    output logic                   o_snap_busy,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_is_status,
    output logic                   o_matched_any,
    output logic                   o_last
);
    import klsf_pkg::*;

    localparam int IW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;

    logic [7:0]       r_snap [KEY_CHARS];
    logic             r_busy, n_busy;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_status, n_status;
    logic             r_matched, n_matched;
    logic             r_last, n_last;
    logic             out_free;

    assign out_free = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_status    = r_status;
        n_matched   = r_matched;
        n_last      = r_last;
        n_busy      = r_busy;
        o_pop       = 1'b0;
        if (out_free) begin
            n_out_valid = ~i_empty;
            if (!i_empty) begin
                if (r_idx < i_head.len) begin
                    n_byte    = r_snap[r_idx[IW-1:0]];
                    n_status  = 1'b0;
                    n_matched = 1'b0;
                    n_last    = 1'b0;
                    n_idx     = r_idx + LEN_W'(1);
                end else begin
                    n_byte    = i_head.tail;
                    n_status  = i_head.status;
                    n_matched = i_head.matched;
                    n_last    = 1'b1;
                    n_idx     = '0;
                    o_pop     = 1'b1;
                    if (i_head.len != '0) begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
        if (i_snap_load) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_status  <= n_status;
        r_matched <= n_matched;
        r_last    <= n_last;
        if (i_snap_load) begin
            for (int i = 0; i < KEY_CHARS; i++) begin
                r_snap[i] <= i_key_flat[8*i +: 8];
            end
        end
    end

    assign o_snap_busy   = r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_is_status   = r_status;
    assign o_matched_any = r_matched;
    assign o_last        = r_last;

endmodule

@@ rtl/core/keyed_line_stream_filter_core.sv @@
`timescale 1ns / 1ps
// Keyed line filter: bytes stream in, lines whose leading key (ended by a colon, a newline or
// KEY_CHARS characters) equals the configured key are dropped up to the next newline, and an
// end-of-stream item flushes a partial key and returns a status transfer. An input transfer
// is taken every cycle while the queue has room, except that a byte or flush arriving while a
// key is being collected waits until the previous key burst has drained from the single
// snapshot buffer; results leave through one output register at one per cycle unless
// stalled, so an item that releases a key of n characters yields n + 1 output transfers.
// A four-entry queue sits between the classifier and the output sequencer, and a stalled
// output fills it and then stalls the input. There is no clearing pass after reset.
module keyed_line_stream_filter_core #(
    parameter int KEY_CHARS = klsf_pkg::KEY_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [klsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [klsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_is_status,
    output logic                            o_matched_any,
    output logic                            o_last
);
    import klsf_pkg::*;

    t_push                  push_data;
    logic                   push_valid;
    t_push                  head;
    logic                   fifo_empty;
    logic                   fifo_full;
    logic                   pop;
    logic                   snap_load;
    logic                   snap_busy;
    logic [KEY_CHARS*8-1:0] key_flat;

    klsf_front #(
        .KEY_CHARS (KEY_CHARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_fifo_full  (fifo_full),
        .i_snap_busy  (snap_busy),
        .o_push_valid (push_valid),
        .o_push       (push_data),
        .o_snap_load  (snap_load),
        .o_key_flat   (key_flat)
    );

    klsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    klsf_back #(
        .KEY_CHARS (KEY_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (fifo_empty),
        .o_pop         (pop),
        .i_snap_load   (snap_load),
        .i_key_flat    (key_flat),
        .o_snap_busy   (snap_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_matched_any (o_matched_any),
        .o_last        (o_last)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import klsf_pkg::*;

    localparam int KEY_CHARS   = KEY_CHARS_DEF;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_char;

    typedef struct packed {
        logic [7:0] ch;
        logic       status;
        logic       matched;
        logic       last;
    } t_emit;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_op       = OP_DATA;
    logic [7:0]            in_byte     = 8'h00;
    logic                  out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [7:0]            o_out_byte;
    logic                  o_is_status;
    logic                  o_matched_any;
    logic                  o_last;

    keyed_line_stream_filter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (in_op),
        .i_data_byte   (in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_matched_any (o_matched_any),
        .o_last        (o_last)
    );

    t_in_char stream_q[$];
    t_emit    emitted_q[$];
    int       send_idle_pct = 27;
    int       recv_idle_pct = 51;
    int       mismatches    = 0;
    int       phase_items   = 0;

    // filter state mirrored for prediction
    logic [63:0] m_key [4];
    logic [4:0]  m_len      = 5'd1;
    logic        m_in_key   = 1'b1;
    logic        m_keep     = 1'b1;
    logic        m_dropped  = 1'b0;
    int          m_fill     = 0;
    logic [7:0]  m_store [KEY_CHARS];

    // key the stimulus is aiming at
    logic [7:0]  tgt_key [KEY_CHARS];
    int          tgt_len = 1;

    initial begin
        for (int i = 0; i < 4; i++) m_key[i] = '0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            m_store[i] = 8'h00;
            tgt_key[i] = 8'h00;
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit key_is_match();
        logic [63:0] w;
        if (m_len == 5'd0 || m_fill != int'(m_len)) return 1'b0;
        for (int i = 0; i < m_fill; i++) begin
            w = m_key[i >> 3];
            if (m_store[i] != w[(i & 7) * 8 +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void emit_char(logic [7:0] ch, logic st, logic m);
        t_emit e;
        e.ch      = ch;
        e.status  = st;
        e.matched = m;
        e.last    = 1'b0;
        emitted_q.insert(emitted_q.size(), e);
    endfunction

    function automatic void filter_byte(logic op, logic [7:0] c);
        int    n0;
        t_emit e;
        n0 = emitted_q.size();
        if (op == OP_DATA) begin
            if (m_in_key) begin
                if (c == CHAR_COLON || c == CHAR_NEWLINE || m_fill >= KEY_CHARS) begin
                    if (key_is_match()) begin
                        m_keep    = 1'b0;
                        m_dropped = 1'b1;
                    end else begin
                        m_keep = 1'b1;
                        for (int i = 0; i < m_fill; i++) emit_char(m_store[i], 1'b0, 1'b0);
                        emit_char(c, 1'b0, 1'b0);
                    end
                    m_in_key = (c == CHAR_NEWLINE);
                    m_fill   = 0;
                end else begin
                    m_store[m_fill] = c;
                    m_fill++;
                end
            end else begin
                if (m_keep) emit_char(c, 1'b0, 1'b0);
                if (c == CHAR_NEWLINE) m_in_key = 1'b1;
            end
        end else begin
            if (m_in_key)
                for (int i = 0; i < m_fill; i++) emit_char(m_store[i], 1'b0, 1'b0);
            emit_char(8'h00, 1'b1, m_dropped);
            m_in_key  = 1'b1;
            m_keep    = 1'b1;
            m_dropped = 1'b0;
            m_fill    = 0;
        end
        if (emitted_q.size() > n0) begin
            e = emitted_q.pop_back();
            e.last = 1'b1;
            emitted_q.insert(emitted_q.size(), e);
        end
    endfunction

    // input side: one item per accepted transfer
    always @(posedge i_clk) begin
        t_in_char nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) filter_byte(in_op, in_byte);
            if (!in_valid || !o_in_stall) begin
                if (stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = stream_q.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= nxt.op;
                    in_byte  <= nxt.ch;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_emit want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (emitted_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb_top: transfer with nothing pending, byte %02h st %0b",
                                 o_out_byte, o_is_status);
                end else begin
                    want = emitted_q.pop_front();
                    if (o_out_byte !== want.ch || o_is_status !== want.status ||
                        o_matched_any !== want.matched || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb_top: mismatch exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     want.ch, want.status, want.matched, want.last,
                                     o_out_byte, o_is_status, o_matched_any, o_last);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic push_item(logic op, logic [7:0] c);
        t_in_char it;
        it.op = op;
        it.ch = c;
        stream_q.insert(stream_q.size(), it);
        phase_items++;
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) push_item(OP_DATA, s[i]);
    endtask

    task automatic wait_drained();
        while (stream_q.size() > 0 || in_valid || emitted_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cfg_data  <= {$urandom, $urandom};
        case (idx)
            CFG_KEY_LO:     m_key[0] = d;
            CFG_KEY_MID_LO: m_key[1] = d;
            CFG_KEY_MID_HI: m_key[2] = d;
            CFG_KEY_HI:     m_key[3] = {8'h00, d[KEY_HI_W-1:0]};
            CFG_KEY_LEN:    m_len    = d[LEN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pack_word(int w);
        logic [63:0] d;
        d = {$urandom, $urandom};
        for (int b = 0; b < 8; b++)
            if (w * 8 + b < KEY_CHARS) d[b * 8 +: 8] = tgt_key[w * 8 + b];
        return d;
    endfunction

    task automatic program_key();
        logic [63:0] d;
        write_reg(CFG_KEY_LO, pack_word(0));
        write_reg(CFG_KEY_MID_LO, pack_word(1));
        write_reg(CFG_KEY_MID_HI, pack_word(2));
        write_reg(CFG_KEY_HI, pack_word(3));
        d = {$urandom, $urandom};
        d[LEN_W-1:0] = tgt_len[LEN_W-1:0];
        write_reg(CFG_KEY_LEN, d);
        // index past the register file, must be ignored
        write_reg(CFG_KEY_LEN + 3'd1 + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    endtask

    function automatic logic [7:0] rand_key_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = 8'h00;
            1: c = 8'hFF;
            2: begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_COLON || c == CHAR_NEWLINE) c = "z";
            end
            default: c = 8'("a" + $urandom_range(0, 2));
        endcase
        return c;
    endfunction

    task automatic push_line();
        int         r;
        int         n;
        logic [7:0] c;
        logic [7:0] delim;
        r = $urandom_range(0, 99);
        if (r >= 85) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) push_item(OP_DATA, 8'($urandom_range(0, 255)));
            return;
        end
        delim = $urandom_range(0, 1) ? CHAR_COLON : CHAR_NEWLINE;
        if (r < 40) begin
            for (int i = 0; i < tgt_len; i++) push_item(OP_DATA, tgt_key[i]);
            if (tgt_len >= KEY_CHARS) delim = 8'($urandom_range(0, 255));
        end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                            : $urandom_range(0, tgt_len + 1);
            for (int i = 0; i < n; i++) begin
                if (i < tgt_len && $urandom_range(0, 3) != 0) c = tgt_key[i];
                else c = rand_key_char();
                push_item(OP_DATA, c);
            end
        end
        push_item(OP_DATA, delim);
        if (delim != CHAR_NEWLINE) begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_NEWLINE) c = "x";
                push_item(OP_DATA, c);
            end
            push_item(OP_DATA, CHAR_NEWLINE);
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key is a single zero byte
        push_item(OP_DATA, 8'h00);
        push_str(":x\n");
        push_item(OP_DATA, 8'hFF);
        push_item(OP_DATA, CHAR_NEWLINE);
        push_item(OP_FLUSH, 8'hFF);
        wait_drained();

        tgt_key[0] = "k";
        tgt_key[1] = "e";
        tgt_key[2] = "y";
        tgt_len    = 3;
        program_key();
        push_str("key:zz\n");
        push_str("key\n");
        push_str("key");
        push_item(OP_FLUSH, 8'h00);
        push_str("ab:c");
        push_item(OP_FLUSH, 8'h5A);

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 27;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            for (int i = 0; i < KEY_CHARS; i++)
                tgt_key[i] = (ph == 2) ? 8'hFF : rand_key_char();
            case (ph)
                0, 2:    tgt_len = KEY_CHARS;
                1:       tgt_len = 0;
                7:       tgt_len = 1;
                default: tgt_len = $urandom_range(1, 6);
            endcase
            program_key();
            phase_items = 0;
            while (phase_items < 18) begin
                push_line();
                if (ph == 4 && !paused && phase_items >= 9) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            push_item(OP_FLUSH, 8'($urandom_range(0, 255)));
        end

        wait_drained();
        if (mismatches == 0 && emitted_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/klsf_pkg.sv
rtl/core/klsf_front.sv
rtl/core/klsf_fifo.sv
rtl/core/klsf_back.sv
rtl/core/keyed_line_stream_filter_core.sv
verif/tb_top.sv
